// ===== hw/rtl/formant_bandpass_bank_defines.svh =====
// Assertion macros shared by the RTL.
`ifndef FORMANT_BANDPASS_BANK_DEFINES_SVH
`define FORMANT_BANDPASS_BANK_DEFINES_SVH

`ifndef ASSERT_OFF
// clocked check, held off while in reset
`define FBB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// clocked check that also runs through reset
`define FBB_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FBB_ASSERT(lbl, prop, msg)
`define FBB_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ===== hw/rtl/fbb_pkg.sv =====
package fbb_pkg;

  localparam int COEF_W        = 18;   // one packed coefficient field
  localparam int X_W           = 16;   // audio sample
  localparam int DIFF_W        = 17;   // x[n] - x[n-2]
  localparam int Y_W           = 24;   // filter output / history
  localparam int TERM_W        = 27;   // one Horner partial term
  localparam int ACC_W         = 44;   // filter accumulator
  localparam int CFG_W         = 54;
  localparam int CFG_IDX_W     = 3;
  localparam int NUM_COEF_REGS = 5;
  localparam int BIT_W         = 5;    // counts coefficient bits
  localparam int SCALE_W       = 15;
  localparam int SCALE_Q16     = 13107; // 0.2 in Q16
  localparam int OUT_FRAC      = 16;

  localparam int DEF_NUM_FORMANTS   = 5;
  localparam int DEF_COEF_FRAC_BITS = 16;

  typedef struct packed {
    logic load;    // latch coefficients, clear accumulator
    logic step;    // one coefficient bit, MSB first
    logic first;   // current bit is the sign bit
    logic update;  // round, saturate, shift output history
  } lane_ctl_t;

  typedef struct packed {
    logic clear;
    logic add;
    logic mul;
  } mix_ctl_t;

endpackage

// ===== hw/rtl/fbb_lane.sv =====
module fbb_lane
  import fbb_pkg::*;
#(
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lane_ctl_t                ctl,
  input  logic [CFG_W-1:0]         coef,
  input  logic signed [DIFF_W-1:0] diff,
  output logic signed [Y_W-1:0]    y_out
);

  localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] Y_MAX = ACC_W'((1 <<< (Y_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] Y_MIN = -(ACC_W'(1) <<< (Y_W - 1));

  logic [COEF_W-1:0]        b0_r, fb1_r, fb2_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [Y_W-1:0]    y1_r, y2_r, y_nxt;
  logic signed [TERM_W-1:0] term, term_s;
  logic signed [ACC_W-1:0]  rnd, shr;

  // partial term for the current bit of each coefficient
  always_comb begin
    term = '0;
    if (b0_r[COEF_W-1]) begin
      term = term + TERM_W'(diff);
    end
    if (fb1_r[COEF_W-1]) begin
      term = term - TERM_W'(y1_r);
    end
    if (fb2_r[COEF_W-1]) begin
      term = term - TERM_W'(y2_r);
    end
    // sign bit of a two's complement coefficient weighs negative
    term_s  = ctl.first ? -term : term;
    acc_nxt = (acc_r <<< 1) + ACC_W'(term_s);
  end

  always_comb begin
    rnd = acc_r + HALF;
    shr = rnd >>> COEF_FRAC_BITS;
    if (shr > Y_MAX) begin
      y_nxt = Y_MAX[Y_W-1:0];
    end else if (shr < Y_MIN) begin
      y_nxt = Y_MIN[Y_W-1:0];
    end else begin
      y_nxt = shr[Y_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      b0_r  <= coef[COEF_W-1:0];
      fb1_r <= coef[2*COEF_W-1:COEF_W];
      fb2_r <= coef[3*COEF_W-1:2*COEF_W];
      acc_r <= '0;
    end else if (ctl.step) begin
      b0_r  <= {b0_r[COEF_W-2:0], 1'b0};
      fb1_r <= {fb1_r[COEF_W-2:0], 1'b0};
      fb2_r <= {fb2_r[COEF_W-2:0], 1'b0};
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y1_r <= '0;
      y2_r <= '0;
    end else if (ctl.update) begin
      y1_r <= y_nxt;
      y2_r <= y1_r;
    end
  end

  assign y_out = y1_r;

endmodule

// ===== hw/rtl/fbb_mix.sv =====
module fbb_mix
  import fbb_pkg::*;
#(
  parameter int NUM_FORMANTS = DEF_NUM_FORMANTS
) (
  input  logic                  clk,
  input  mix_ctl_t              ctl,
  input  logic signed [Y_W-1:0] y_in,
  output logic signed [X_W-1:0] mix_out
);

  localparam int SUM_W  = Y_W + $clog2(NUM_FORMANTS + 1);
  localparam int PROD_W = SUM_W + SCALE_W;
  localparam logic signed [SCALE_W-1:0] SCALE = SCALE_W'(SCALE_Q16);
  localparam logic signed [PROD_W-1:0]  HALF  = PROD_W'(1) <<< (OUT_FRAC - 1);
  localparam logic signed [PROD_W-1:0]  O_MAX = PROD_W'((1 <<< (X_W - 1)) - 1);
  localparam logic signed [PROD_W-1:0]  O_MIN = -(PROD_W'(1) <<< (X_W - 1));

  logic signed [SUM_W-1:0]  sum_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] rnd, shr;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      sum_r <= '0;
    end else if (ctl.add) begin
      sum_r <= sum_r + SUM_W'(y_in);
    end
    if (ctl.mul) begin
      prod_r <= sum_r * SCALE;
    end
  end

  always_comb begin
    rnd = prod_r + HALF;
    shr = rnd >>> OUT_FRAC;
    if (shr > O_MAX) begin
      mix_out = O_MAX[X_W-1:0];
    end else if (shr < O_MIN) begin
      mix_out = O_MIN[X_W-1:0];
    end else begin
      mix_out = shr[X_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/formant_bandpass_bank.sv =====
// Bank of parallel second-order bandpass filters, one result per sample.
// Input channel: in_valid / in_stall with in_sample_in (signed Q1.15).
// Result channel: out_valid / out_stall with out_sample_out (signed Q1.15).
// A beat moves on a rising edge with valid high and stall low.
// Config: cfg_we writes cfg_data into coefficient register cfg_index
// (0..4); other indexes are ignored. Write only while the bank is idle.
// Each filter lane runs a bit-serial multiply-accumulate over the 18
// coefficient bits, MSB first, all lanes in parallel. Then the lanes round
// and update the output history, the lane outputs are summed one lane per
// cycle, the sum is scaled by 0.2 and then loaded into the output register.
// in_stall is low only while no sample is in flight. A result waiting on
// out_stall stays in the output register; the next sample is accepted and
// computed meanwhile, and held before the output until the register frees.
// Reset (rst_n low, synchronous) clears coefficients and all filter history
// and empties the output register.
`include "formant_bandpass_bank_defines.svh"

module formant_bandpass_bank
  import fbb_pkg::*;
#(
  parameter int NUM_FORMANTS   = DEF_NUM_FORMANTS,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [X_W-1:0] in_sample_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [X_W-1:0] out_sample_out,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam int LANE_W = (NUM_FORMANTS > 1) ? $clog2(NUM_FORMANTS) : 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MAC  = 6'b000010,
    S_POST = 6'b000100,
    S_SUM  = 6'b001000,
    S_MUL  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [BIT_W-1:0]         bit_cnt_r, bit_cnt_nxt;
  logic [LANE_W-1:0]        lane_cnt_r, lane_cnt_nxt;
  logic [CFG_W-1:0]         coef_r [NUM_COEF_REGS];
  logic signed [X_W-1:0]    x1_r, x2_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic                     out_valid_r;
  logic signed [X_W-1:0]    out_data_r;
  logic                     in_acc, out_acc, out_free;
  lane_ctl_t                lane_ctl;
  mix_ctl_t                 mix_ctl;
  logic signed [Y_W-1:0]    lane_y [NUM_FORMANTS];
  logic signed [X_W-1:0]    mix_out;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;
  assign out_free = !out_valid_r || out_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEF_REGS; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cfg_we && (32'(cfg_index) < NUM_COEF_REGS)) begin
      coef_r[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    bit_cnt_nxt  = bit_cnt_r;
    lane_cnt_nxt = lane_cnt_r;
    lane_ctl     = '0;
    mix_ctl      = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          lane_ctl.load = 1'b1;
          bit_cnt_nxt   = '0;
          state_nxt     = S_MAC;
        end
      end
      S_MAC: begin
        lane_ctl.step  = 1'b1;
        lane_ctl.first = (bit_cnt_r == '0);
        bit_cnt_nxt    = bit_cnt_r + 1'b1;
        if (bit_cnt_r == BIT_W'(COEF_W - 1)) begin
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        lane_ctl.update = 1'b1;
        mix_ctl.clear   = 1'b1;
        lane_cnt_nxt    = '0;
        state_nxt       = S_SUM;
      end
      S_SUM: begin
        mix_ctl.add  = 1'b1;
        lane_cnt_nxt = lane_cnt_r + 1'b1;
        if (lane_cnt_r == LANE_W'(NUM_FORMANTS - 1)) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        mix_ctl.mul = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bit_cnt_r   <= '0;
      lane_cnt_r  <= '0;
      x1_r        <= '0;
      x2_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      lane_cnt_r <= lane_cnt_nxt;
      if (in_acc) begin
        x1_r <= in_sample_in;
        x2_r <= x1_r;
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      diff_r <= DIFF_W'(in_sample_in) - DIFF_W'(x2_r);
    end
    if (state_r == S_OUT && out_free) begin
      out_data_r <= mix_out;
    end
  end

  for (genvar k = 0; k < NUM_FORMANTS; k++) begin : g_lane
    logic [CFG_W-1:0] lane_coef;
    if (k < NUM_COEF_REGS) begin : g_reg
      assign lane_coef = coef_r[k];
    end else begin : g_zero
      assign lane_coef = '0;
    end
    fbb_lane #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_lane (
      .clk  (clk),
      .rst_n(rst_n),
      .ctl  (lane_ctl),
      .coef (lane_coef),
      .diff (diff_r),
      .y_out(lane_y[k])
    );
  end

  fbb_mix #(
    .NUM_FORMANTS(NUM_FORMANTS)
  ) u_mix (
    .clk    (clk),
    .ctl    (mix_ctl),
    .y_in   (lane_y[lane_cnt_r]),
    .mix_out(mix_out)
  );

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_data_r;

  `FBB_ASSERT(a_start_mac, in_acc |=> (state_r == S_MAC), "accepted beat did not start MAC")
  `FBB_ASSERT(a_mac_done,
    (state_r == S_MAC && bit_cnt_r == BIT_W'(COEF_W - 1)) |=> (state_r == S_POST),
    "MAC loop did not end after the last coefficient bit")
  `FBB_ASSERT(a_out_hold, (state_r == S_OUT && out_valid_r && out_stall) |=>
    (state_r == S_OUT), "result left the datapath while output register was full")
  `FBB_ASSERT(a_busy_no_take, (state_r != S_IDLE) |-> !in_acc,
    "beat accepted while a sample is in flight")
  `FBB_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid_r, "output not empty after reset")

endmodule

// ===== test/tb_formant_bandpass_bank.sv =====
module tb_formant_bandpass_bank;
  import fbb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NF           = DEF_NUM_FORMANTS;
  localparam int FRAC         = DEF_COEF_FRAC_BITS;
  localparam int DRAIN_CYCLES = 2 * (23 + NF);
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 104;
  localparam int MAX_REPORTS  = 10;
  localparam int LAST_INDEX   = (1 << CFG_IDX_W) - 1;

  localparam logic [COEF_W-1:0] COEF_MAX  = 18'h1FFFF;
  localparam logic [COEF_W-1:0] COEF_MIN  = 18'h20000;
  localparam logic [COEF_W-1:0] COEF_ONES = 18'h3FFFF;

  typedef logic signed [X_W-1:0] sample_t;
  typedef enum int {COEF_STABLE, COEF_RANDOM, COEF_EXTREME, COEF_MIXED} coef_style_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  sample_t              in_sample_in = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  sample_t              out_sample_out;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // shadow of the coefficient registers and the filter history
  logic [CFG_W-1:0]        coef_regs [NUM_COEF_REGS];
  sample_t                 x_hist [2];
  logic signed [Y_W-1:0]   y_hist [NF][2];

  sample_t expected_samples [$];
  int      fail_count = 0;
  bit      no_gaps = 1'b0;
  int      stall_left = 0;
  sample_t last_sample = '0;

  formant_bandpass_bank #(
    .NUM_FORMANTS  (NF),
    .COEF_FRAC_BITS(FRAC)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample_out(out_sample_out),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("Some tests failed");
    $finish;
  end

  // add half, then floor
  function automatic longint round_shift(input longint v, input int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clamp(input longint v, input int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic sample_t predict_bank_output(input sample_t x);
    longint diff, acc, total;
    logic [CFG_W-1:0] c;
    logic signed [COEF_W-1:0] b0, fb1, fb2;
    logic signed [Y_W-1:0] y;
    int k;
    diff = longint'(x) - longint'(x_hist[1]);
    total = 0;
    for (k = 0; k < NF; k++) begin
      c = (k < NUM_COEF_REGS) ? coef_regs[k] : '0;
      b0 = c[17:0];
      fb1 = c[35:18];
      fb2 = c[53:36];
      acc = longint'(b0) * diff - longint'(fb1) * longint'(y_hist[k][0])
            - longint'(fb2) * longint'(y_hist[k][1]);
      y = Y_W'(clamp(round_shift(acc, FRAC), Y_W));
      y_hist[k][1] = y_hist[k][0];
      y_hist[k][0] = y;
      total += longint'(y);
    end
    x_hist[1] = x_hist[0];
    x_hist[0] = x;
    return sample_t'(clamp(round_shift(total * SCALE_Q16, OUT_FRAC), X_W));
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(21, 80);
  endfunction

  function automatic logic [CFG_W-1:0] pack_coefs(input logic [COEF_W-1:0] b0,
                                                   input logic [COEF_W-1:0] fb1,
                                                   input logic [COEF_W-1:0] fb2);
    return {fb2, fb1, b0};
  endfunction

  function automatic logic [COEF_W-1:0] extreme_field();
    case ($urandom_range(0, 4))
      0: return COEF_MAX;
      1: return COEF_MIN;
      2: return COEF_ONES;
      3: return 18'd1;
      default: return '0;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] make_coef(input coef_style_t style);
    logic [63:0] raw;
    int lim, fb2, fb1, b0;
    if (style == COEF_MIXED) style = coef_style_t'($urandom_range(0, 2));
    case (style)
      COEF_STABLE: begin
        // pole radius squared 0.8..0.999, first feedback inside the stability triangle
        fb2 = $urandom_range(52429, 65470);
        lim = 65536 + fb2 - 1;
        fb1 = $urandom_range(0, 2 * lim) - lim;
        b0 = $urandom_range(16, 8192);
        if ($urandom_range(0, 3) == 0) b0 = -b0;
        return pack_coefs(COEF_W'(b0), COEF_W'(fb1), COEF_W'(fb2));
      end
      COEF_EXTREME: return pack_coefs(extreme_field(), extreme_field(), extreme_field());
      default: begin
        raw = {$urandom, $urandom};
        return raw[CFG_W-1:0];
      end
    endcase
  endfunction

  function automatic sample_t make_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: last_sample = sample_t'($urandom);
      5, 6: last_sample = sample_t'($urandom_range(0, 1023) - 512);
      7: last_sample = $urandom_range(0, 1) ? sample_t'(32767) : sample_t'(-32768);
      8: last_sample = sample_t'($urandom_range(0, 2) - 1);
      default: ;  // hold the previous value: DC input
    endcase
    return last_sample;
  endfunction

  task automatic report_mismatch(input string what, input sample_t want, input sample_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (no_gaps || $urandom_range(0, 1)) begin
      out_stall <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_stall <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    sample_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("output beat with nothing pending", 'x, out_sample_out);
      end else begin
        want = expected_samples.pop_front();
        if (out_sample_out !== want) report_mismatch("sample_out", want, out_sample_out);
      end
    end
  end

  task automatic send_sample(input sample_t s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_in <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_samples.push_back(predict_bank_output(s));
  endtask

  task automatic drain_bank();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // only while the bank is idle
  task automatic write_coef(input int index, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= CFG_IDX_W'(index);
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (index < NUM_COEF_REGS) coef_regs[index] = data;
  endtask

  task automatic test_reset_state();
    send_sample(sample_t'(32767));
    send_sample(sample_t'(-32768));
    send_sample(sample_t'(0));
  endtask

  // full-scale fields; negative first feedback of -2.0 makes its filter run away
  // into the 24-bit limit, which then drives the output into saturation
  task automatic test_coef_extremes();
    sample_t steps [12] = '{32767, -32768, 32767, -32768, 0, -1, 1, 0,
                            32767, 32767, -32768, -32768};
    drain_bank();
    write_coef(0, pack_coefs(COEF_MAX, '0, '0));
    write_coef(1, pack_coefs(COEF_MIN, '0, '0));
    write_coef(2, pack_coefs(18'h01000, COEF_MIN, '0));
    write_coef(3, pack_coefs(18'd1, '0, COEF_MAX));
    write_coef(4, pack_coefs(COEF_ONES, COEF_ONES, COEF_ONES));
    foreach (steps[i]) send_sample(steps[i]);
  endtask

  // writes past the last coefficient register must not land anywhere
  task automatic test_ignored_index();
    int idx;
    drain_bank();
    write_coef(0, '0);
    for (idx = NUM_COEF_REGS; idx <= LAST_INDEX; idx++) write_coef(idx, '1);
    repeat (4) send_sample(make_sample());
  endtask

  task automatic test_random_settings();
    int p, k;
    coef_style_t style;
    logic [63:0] raw;
    for (p = 0; p < PHASES; p++) begin
      drain_bank();
      no_gaps = (p % 4 == 3);
      case (p % 5)
        0, 3: style = COEF_STABLE;
        1: style = COEF_RANDOM;
        2: style = COEF_EXTREME;
        default: style = COEF_MIXED;
      endcase
      for (k = 0; k < NUM_COEF_REGS; k++) write_coef(k, make_coef(style));
      if ($urandom_range(0, 2) == 0) begin
        raw = {$urandom, $urandom};
        write_coef($urandom_range(NUM_COEF_REGS, LAST_INDEX), raw[CFG_W-1:0]);
      end
      repeat (PHASE_ITEMS) send_sample(make_sample());
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    foreach (coef_regs[k]) coef_regs[k] = '0;
    x_hist[0] = '0;
    x_hist[1] = '0;
    foreach (y_hist[k, j]) y_hist[k][j] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_coef_extremes();
    test_ignored_index();
    test_random_settings();
    drain_bank();
    if (fail_count == 0 && expected_samples.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
